FILE: hw/rtl/smh_pkg.sv
package smh_pkg;

    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 48;

    // op codes on the input side
    localparam logic [1:0] OP_MOVE = 2'd0;
    localparam logic [1:0] OP_HOME = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [7:0] SEARCH_LIMIT   = 8'd205;
    localparam logic [7:0] NOMINAL_SPAN   = 8'd200;
    localparam logic [7:0] SPAN_TOLERANCE = 8'd2;
    localparam logic [7:0] PRE_STEPS      = 8'd25;
    localparam logic [7:0] RETRY_BELOW    = 8'd5;

    localparam logic [7:0] PWR_FULL = 8'hFF;
    localparam logic [7:0] PWR_HOLD = 8'h2F;
    localparam logic [7:0] PWR_OFF  = 8'h00;
    localparam logic [7:0] SPAN_NONE = 8'hFF;

    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_FULL = 2'd1;
    localparam logic [1:0] MODE_PWM  = 2'd2;

    localparam logic [1:0] CODE_OK        = 2'd0;
    localparam logic [1:0] CODE_NONE_BOTH = 2'd1;
    localparam logic [1:0] CODE_NONE_BACK = 2'd2;
    localparam logic [1:0] CODE_SPAN_ERR  = 2'd3;

    typedef enum logic [1:0] {
        KIND_MOVE,
        KIND_HOME,
        KIND_TICK,
        KIND_NONE
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MOVE,
        PH_PRE,
        PH_FWD,
        PH_BACK_ALT,
        PH_BACK_MAIN,
        PH_BACK_RETRY
    } run_phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] step_count;
        logic       reverse;
        logic [3:0] hold_lvl;
        logic       ref_level;
        logic       ref_edge;
    } entry_t;

    function automatic logic [3:0] coil_of(input logic [1:0] idx);
        logic [3:0] pat;
        unique case (idx)
            2'd0: pat = 4'b1010;
            2'd1: pat = 4'b0110;
            2'd2: pat = 4'b0101;
            2'd3: pat = 4'b1001;
            default: pat = 4'b1010;
        endcase
        return pat;
    endfunction

endpackage

FILE: hw/rtl/smh_front.sv
module smh_front (
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: step_count[7:0], reverse[8], hold_lvl[12:9], ref_level[13], ref_edge[14]
    input  logic [smh_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: op[1:0]
    input  logic [smh_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  logic                           q_full,
    output logic                           push,
    output smh_pkg::entry_t                entry
);
    import smh_pkg::*;

    kind_t kind;

    always_comb
    begin
        unique case (s_axis_tuser)
            OP_MOVE: kind = KIND_MOVE;
            OP_HOME: kind = KIND_HOME;
            OP_TICK: kind = KIND_TICK;
            default: kind = KIND_NONE;
        endcase
    end

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

    assign entry.kind       = kind;
    assign entry.step_count = s_axis_tdata[7:0];
    assign entry.reverse    = s_axis_tdata[8];
    assign entry.hold_lvl   = s_axis_tdata[12:9];
    assign entry.ref_level  = s_axis_tdata[13];
    assign entry.ref_edge   = s_axis_tdata[14];

endmodule

FILE: hw/rtl/smh_queue.sv
module smh_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  smh_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output smh_pkg::entry_t head_entry
);
    import smh_pkg::*;

    entry_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hw/rtl/smh_back.sv
module smh_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  smh_pkg::entry_t                 head_entry,
    output logic                            pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [smh_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import smh_pkg::*;

    run_phase_t phase_reg, phase_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] zpos_reg, zpos_next;
    logic       zflag_reg, zflag_next;
    logic       dir_reg, dir_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] power_reg, power_next;
    logic [7:0] scount_reg, scount_next;
    logic [1:0] code_reg, code_next;
    logic       fail_reg, fail_next;
    logic [7:0] span_reg, span_next;
    logic [3:0] hold_reg, hold_next;
    logic       done;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // shared decode of the word at the queue head
    logic       is_move, is_home, is_tick, stepping, searching;
    logic [1:0] idx_step;
    logic [7:0] pos_step, zpos_step, scount_inc, span_end, hold_pwr;
    logic       zflag_step, found, missed, ended, span_ok, retry;
    logic [8:0] span_wide;
    logic [1:0] mode;
    logic [7:0] duty;

    assign pop = head_valid && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        is_move   = (head_entry.kind == KIND_MOVE) && (phase_reg == PH_IDLE);
        is_home   = (head_entry.kind == KIND_HOME) && (phase_reg == PH_IDLE);
        is_tick   = (head_entry.kind == KIND_TICK);
        stepping  = is_tick && (phase_reg != PH_IDLE);
        searching = is_tick && (phase_reg == PH_FWD || phase_reg == PH_BACK_ALT ||
                                phase_reg == PH_BACK_MAIN || phase_reg == PH_BACK_RETRY);
        idx_step  = dir_reg ? idx_reg - 2'd1 : idx_reg + 2'd1;
        pos_step  = dir_reg ? pos_reg - 8'd1 : pos_reg + 8'd1;
        zpos_step = head_entry.ref_level ? zpos_reg : pos_step;
        zflag_step = (zflag_reg && !head_entry.ref_level) || head_entry.ref_edge;
        scount_inc = scount_reg + 8'd1;
        found     = zflag_step;
        missed    = !zflag_step && (scount_inc >= SEARCH_LIMIT);
        ended     = searching && (found || missed);
        span_end  = found ? scount_reg : SPAN_NONE;
        span_wide = {1'b0, span_end};
        span_ok   = (span_wide + {1'b0, SPAN_TOLERANCE} >= {1'b0, NOMINAL_SPAN}) &&
                    (span_wide <= {1'b0, NOMINAL_SPAN} + {1'b0, SPAN_TOLERANCE});
        retry     = span_end < RETRY_BELOW;
        hold_pwr  = {2'b00, head_entry.hold_lvl, 2'b00};
    end

    // run phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (is_move && head_entry.step_count != 8'd0)
                begin
                    phase_next = PH_MOVE;
                end
                else if (is_home)
                begin
                    phase_next = (PRE_STEPS == 8'd0) ? PH_FWD : PH_PRE;
                end
            end
            PH_MOVE:
            begin
                if (stepping && left_reg == 8'd1)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_PRE:
            begin
                if (stepping && left_reg == 8'd1)
                begin
                    phase_next = PH_FWD;
                end
            end
            PH_FWD:
            begin
                if (ended)
                begin
                    phase_next = found ? PH_BACK_MAIN : PH_BACK_ALT;
                end
            end
            PH_BACK_ALT:
            begin
                if (ended)
                begin
                    phase_next = found ? PH_BACK_MAIN : PH_IDLE;
                end
            end
            PH_BACK_MAIN:
            begin
                if (ended)
                begin
                    phase_next = (found && retry) ? PH_BACK_RETRY : PH_IDLE;
                end
            end
            PH_BACK_RETRY:
            begin
                if (ended)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // datapath updates
    always_comb
    begin
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        zpos_next   = zpos_reg;
        zflag_next  = zflag_reg;
        dir_next    = dir_reg;
        left_next   = left_reg;
        power_next  = power_reg;
        scount_next = scount_reg;
        code_next   = code_reg;
        fail_next   = fail_reg;
        span_next   = span_reg;
        hold_next   = hold_reg;
        done        = 1'b0;

        if (is_move)
        begin
            dir_next   = head_entry.reverse;
            hold_next  = head_entry.hold_lvl;
            left_next  = head_entry.step_count;
            power_next = PWR_FULL;
            if (head_entry.step_count == 8'd0)
            begin
                power_next = hold_pwr;
                done       = 1'b1;
            end
        end
        else if (is_home)
        begin
            pos_next   = 8'd0;
            zpos_next  = 8'd0;
            code_next  = CODE_OK;
            dir_next   = 1'b0;
            power_next = PWR_FULL;
            left_next  = PRE_STEPS;
            if (PRE_STEPS == 8'd0)
            begin
                fail_next   = 1'b0;
                scount_next = 8'd0;
            end
        end
        else if (is_tick && !stepping)
        begin
            zflag_next = zflag_reg || head_entry.ref_edge;
        end
        else if (stepping)
        begin
            idx_next   = idx_step;
            pos_next   = pos_step;
            zpos_next  = zpos_step;
            zflag_next = zflag_step;
            if (!searching)
            begin
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1)
                begin
                    if (phase_reg == PH_MOVE)
                    begin
                        power_next = {2'b00, hold_reg, 2'b00};
                        done       = 1'b1;
                    end
                    else
                    begin
                        dir_next    = 1'b0;
                        fail_next   = 1'b0;
                        scount_next = 8'd0;
                        power_next  = PWR_FULL;
                    end
                end
            end
            else if (!ended)
            begin
                scount_next = scount_inc;
            end
            else
            begin
                scount_next = scount_inc;
                span_next   = span_end;
                power_next  = PWR_HOLD;
                if (phase_next != PH_IDLE)
                begin
                    // another backward search follows
                    dir_next    = 1'b1;
                    fail_next   = 1'b0;
                    scount_next = 8'd0;
                    power_next  = PWR_FULL;
                end
                else
                begin
                    done = 1'b1;
                    if (missed)
                    begin
                        fail_next = 1'b1;
                    end
                    if (phase_reg == PH_BACK_ALT)
                    begin
                        code_next = CODE_NONE_BOTH;
                    end
                    else if (phase_reg == PH_BACK_MAIN && missed)
                    begin
                        code_next = CODE_NONE_BACK;
                    end
                    else if (!span_ok)
                    begin
                        fail_next = 1'b1;
                        code_next = CODE_SPAN_ERR;
                    end
                    else
                    begin
                        pos_next  = 8'd0;
                        zpos_next = 8'd0;
                        code_next = CODE_OK;
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (power_next == PWR_FULL)
        begin
            mode = MODE_FULL;
            duty = 8'd0;
        end
        else if (power_next == PWR_OFF)
        begin
            mode = MODE_OFF;
            duty = 8'd0;
        end
        else
        begin
            mode = MODE_PWM;
            duty = power_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {4'b0000, span_next, fail_next, code_next, done,
                              (phase_next != PH_IDLE), zflag_next, zpos_next, pos_next,
                              duty, mode, coil_of(idx_next)};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            idx_reg       <= 2'd0;
            pos_reg       <= 8'd0;
            zpos_reg      <= 8'd0;
            zflag_reg     <= 1'b0;
            dir_reg       <= 1'b0;
            left_reg      <= 8'd0;
            power_reg     <= PWR_OFF;
            scount_reg    <= 8'd0;
            code_reg      <= CODE_OK;
            fail_reg      <= 1'b0;
            span_reg      <= 8'd0;
            hold_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg  <= phase_next;
                idx_reg    <= idx_next;
                pos_reg    <= pos_next;
                zpos_reg   <= zpos_next;
                zflag_reg  <= zflag_next;
                dir_reg    <= dir_next;
                left_reg   <= left_next;
                power_reg  <= power_next;
                scount_reg <= scount_next;
                code_reg   <= code_next;
                fail_reg   <= fail_next;
                span_reg   <= span_next;
                hold_reg   <= hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

FILE: hw/rtl/stepper_move_and_homing.sv
// channel   dir  tdata / tuser (low bit first)
// s_axis    in   tdata: step_count, reverse, hold_lvl, ref_level, ref_edge; tuser: op
// m_axis    out  tdata: coil_pattern, drive_mode, pwm_duty, motor_position, zone_position,
//                       in_ref_zone, busy_res, done_res, home_code, ref_fail, measured_span
//
// One word in and one word out per cycle sustained while the output is not stalled;
// a word passes from input to output through the two-entry queue, then through the
// step/search logic into the output register, which the back end loads as it pops the word.
// rst_n clears the run state, the queue and the output valid. A stalled output holds
// the back end; the queue keeps taking input until both entries are filled.
module stepper_move_and_homing (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: step_count[7:0], reverse[8], hold_lvl[12:9], ref_level[13], ref_edge[14]
    input  logic [smh_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: op[1:0]
    input  logic [smh_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: coil_pattern[3:0], drive_mode[5:4], pwm_duty[13:6], motor_position[21:14],
    // zone_position[29:22], in_ref_zone[30], busy_res[31], done_res[32],
    // home_code[34:33], ref_fail[35], measured_span[43:36]
    output logic [smh_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import smh_pkg::*;

    logic   q_full;
    logic   push;
    logic   pop;
    logic   head_valid;
    entry_t push_entry;
    entry_t head_entry;

    smh_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .push          (push),
        .entry         (push_entry)
    );

    smh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    smh_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
